@@ rtl/core/dpks_pkg.sv @@
// shared types and constants for the kappa squared datapath
package dpks_pkg;

	// classified item handed from the front end to the divider back end
	typedef struct packed {
		logic signed [33:0] da;
		logic [35:0]        mdr;
		logic [35:0]        mar;
		logic               neg;
		logic [39:0]        rr;
		logic               zero;
	} mid_t;

	localparam int unsigned QDEPTH = 4;
	localparam int unsigned QAW    = 2;
	localparam int unsigned QCW    = 3;

	localparam logic [18:0] KSQ_MAX = 19'd262144;

endpackage

@@ rtl/core/dpks_front.sv @@
// front end: dot products, magnitudes and zero separation check
module dpks_front import dpks_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               adv,
	input  logic               in_vld,
	input  logic signed [15:0] donor_x,
	input  logic signed [15:0] donor_y,
	input  logic signed [15:0] donor_z,
	input  logic signed [15:0] acceptor_x,
	input  logic signed [15:0] acceptor_y,
	input  logic signed [15:0] acceptor_z,
	input  logic signed [19:0] sep_x,
	input  logic signed [19:0] sep_y,
	input  logic signed [19:0] sep_z,
	output logic               out_vld,
	output mid_t               out_data
);

	logic               vld_s1;
	logic               vld_s2;
	logic signed [31:0] pda_s1 [3];
	logic signed [35:0] pdr_s1 [3];
	logic signed [35:0] par_s1 [3];
	logic signed [39:0] prr_s1 [3];
	logic signed [33:0] da_sum;
	logic signed [36:0] dr_sum;
	logic signed [36:0] ar_sum;
	logic [39:0]        rr_sum;
	mid_t               nxt;
	mid_t               data_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_vld;
			vld_s2 <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pda_s1[0] <= 32'(donor_x) * 32'(acceptor_x);
			pda_s1[1] <= 32'(donor_y) * 32'(acceptor_y);
			pda_s1[2] <= 32'(donor_z) * 32'(acceptor_z);
			pdr_s1[0] <= 36'(donor_x) * 36'(sep_x);
			pdr_s1[1] <= 36'(donor_y) * 36'(sep_y);
			pdr_s1[2] <= 36'(donor_z) * 36'(sep_z);
			par_s1[0] <= 36'(acceptor_x) * 36'(sep_x);
			par_s1[1] <= 36'(acceptor_y) * 36'(sep_y);
			par_s1[2] <= 36'(acceptor_z) * 36'(sep_z);
			prr_s1[0] <= 40'(sep_x) * 40'(sep_x);
			prr_s1[1] <= 40'(sep_y) * 40'(sep_y);
			prr_s1[2] <= 40'(sep_z) * 40'(sep_z);
			data_s2   <= nxt;
		end
	end

	always_comb begin
		da_sum = 34'(pda_s1[0]) + 34'(pda_s1[1]) + 34'(pda_s1[2]);
		dr_sum = 37'(pdr_s1[0]) + 37'(pdr_s1[1]) + 37'(pdr_s1[2]);
		ar_sum = 37'(par_s1[0]) + 37'(par_s1[1]) + 37'(par_s1[2]);
		rr_sum = 40'(prr_s1[0][38:0]) + 40'(prr_s1[1][38:0]) + 40'(prr_s1[2][38:0]);
		nxt.da   = da_sum;
		nxt.mdr  = dr_sum[36] ? 36'(-dr_sum) : dr_sum[35:0];
		nxt.mar  = ar_sum[36] ? 36'(-ar_sum) : ar_sum[35:0];
		nxt.neg  = dr_sum[36] ^ ar_sum[36];
		nxt.rr   = rr_sum;
		nxt.zero = (rr_sum == 40'd0);
	end

	assign out_vld  = vld_s2;
	assign out_data = data_s2;

endmodule

@@ rtl/core/dpks_queue.sv @@
// short queue between front end and back end
module dpks_queue import dpks_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic wr,
	input  mid_t wdata,
	input  logic rd,
	output mid_t rdata,
	output logic full,
	output logic empty
);

	mid_t           mem_q [QDEPTH];
	logic [QAW-1:0] wptr_q;
	logic [QAW-1:0] rptr_q;
	logic [QCW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			cnt_q  <= '0;
		end else begin
			if (wr) wptr_q <= wptr_q + QAW'(1);
			if (rd) rptr_q <= rptr_q + QAW'(1);
			if (wr && !rd) cnt_q <= cnt_q + QCW'(1);
			else if (rd && !wr) cnt_q <= cnt_q - QCW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr) mem_q[wptr_q] <= wdata;
	end

	assign rdata = mem_q[rptr_q];
	assign full  = (cnt_q == QCW'(QDEPTH));
	assign empty = (cnt_q == '0);

endmodule

@@ rtl/core/dpks_back.sv @@
// back end: r-term product, pipelined divider, kappa squared and result buffer
module dpks_back import dpks_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_empty,
	input  mid_t        in_data,
	output logic        in_rd,
	output logic [18:0] kappa_sq,
	output logic        zero_separation,
	output logic        empty,
	input  logic        pop
);

	typedef struct packed {
		logic signed [33:0] da;
		logic               neg;
		logic [39:0]        rr;
		logic               zero;
	} side_t;

	typedef struct packed {
		logic [73:0]        rem;
		logic [40:0]        quo;
		logic [39:0]        den;
		logic signed [33:0] da;
		logic               neg;
		logic               zero;
		logic               ovf;
	} divst_t;

	typedef struct packed {
		logic [18:0] ksq;
		logic        zero;
	} res_t;

	localparam logic [41:0] T_CLAMP = 42'd1 << 40;
	localparam logic [41:0] K_CLAMP = 42'd1 << 30;
	localparam logic [62:0] RND_HALF = 63'd1 << 39;

	logic        adv;
	logic        vld_s1, vld_s2, vld_s4, vld_s5, vld_s6;
	logic [37:0] m3dr;
	logic [55:0] plo_s1, phi_s1;
	side_t       sd_s1, sd_s2;
	logic [73:0] num_s2;
	divst_t      dv_s [0:41];
	logic        dv_vld [0:41];
	logic [41:0] tq_s4;
	logic signed [33:0] da_s4;
	logic        neg_s4, zero_s4, zero_s5, zero_s6;
	logic [30:0] km_s5;
	logic [61:0] sq_s6;

	logic        rnd;
	logic [41:0] q2;
	logic [41:0] tq;
	logic signed [42:0] tsg;
	logic signed [42:0] kv;
	logic [41:0] kmag;
	logic [62:0] rsum;
	logic [22:0] rsh;
	res_t        res;

	res_t        oq_q [2];
	logic        owp_q, orp_q;
	logic [1:0]  ocnt_q;
	logic        opush, opop;

	// whole back end moves whenever the result buffer has room
	assign adv   = (ocnt_q != 2'd2);
	assign in_rd = adv && !in_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
			vld_s6 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_rd;
			vld_s2 <= vld_s1;
			vld_s4 <= dv_vld[41];
			vld_s5 <= vld_s4;
			vld_s6 <= vld_s5;
		end
	end

	assign m3dr = {2'b00, in_data.mdr} + {1'b0, in_data.mdr, 1'b0};

	always_ff @(posedge clk) begin
		if (adv) begin
			plo_s1 <= 56'(m3dr) * 56'(in_data.mar[17:0]);
			phi_s1 <= 56'(m3dr) * 56'(in_data.mar[35:18]);
			sd_s1  <= '{da: in_data.da, neg: in_data.neg, rr: in_data.rr,
				zero: in_data.zero};
			num_s2 <= 74'(plo_s1) + (74'(phi_s1) << 18);
			sd_s2  <= sd_s1;
			dv_s[0].rem  <= num_s2;
			dv_s[0].quo  <= '0;
			dv_s[0].den  <= sd_s2.rr;
			dv_s[0].da   <= sd_s2.da;
			dv_s[0].neg  <= sd_s2.neg;
			dv_s[0].zero <= sd_s2.zero;
			dv_s[0].ovf  <= (81'(num_s2) >= (81'(sd_s2.rr) << 41));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) dv_vld[0] <= 1'b0;
		else if (adv) dv_vld[0] <= vld_s2;
	end

	// one quotient bit per stage, most significant first
	for (genvar s = 0; s < 41; s++) begin : g_div
		logic [80:0] sh;
		logic        ge;
		divst_t      nx;
		always_comb begin
			sh = 81'(dv_s[s].den) << (40 - s);
			ge = (81'(dv_s[s].rem) >= sh);
			nx = dv_s[s];
			if (ge) nx.rem = 74'(81'(dv_s[s].rem) - sh);
			nx.quo[40-s] = ge;
		end
		always_ff @(posedge clk) begin
			if (adv) dv_s[s+1] <= nx;
		end
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) dv_vld[s+1] <= 1'b0;
			else if (adv) dv_vld[s+1] <= dv_vld[s];
		end
	end

	// round half away, clamp, drop r term on zero separation
	always_comb begin
		rnd = ({dv_s[41].rem[40:0], 1'b0} >= 42'(dv_s[41].den));
		q2  = 42'(dv_s[41].quo) + 42'(rnd);
		if (dv_s[41].zero) tq = '0;
		else if (dv_s[41].ovf || q2 > T_CLAMP) tq = T_CLAMP;
		else tq = q2;
	end

	always_comb begin
		tsg  = neg_s4 ? -$signed(43'(tq_s4)) : $signed(43'(tq_s4));
		kv   = 43'(da_s4) - tsg;
		kmag = kv[42] ? 42'(-kv) : kv[41:0];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			tq_s4   <= tq;
			da_s4   <= dv_s[41].da;
			neg_s4  <= dv_s[41].neg;
			zero_s4 <= dv_s[41].zero;
			km_s5   <= (kmag > K_CLAMP) ? K_CLAMP[30:0] : kmag[30:0];
			zero_s5 <= zero_s4;
			sq_s6   <= 62'(km_s5) * 62'(km_s5);
			zero_s6 <= zero_s5;
		end
	end

	always_comb begin
		rsum     = 63'(sq_s6) + RND_HALF;
		rsh      = rsum[62:40];
		res.ksq  = (rsh > 23'(KSQ_MAX)) ? KSQ_MAX : rsh[18:0];
		res.zero = zero_s6;
	end

	// two entry result buffer
	assign opush = vld_s6 && adv;
	assign opop  = pop && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			owp_q  <= 1'b0;
			orp_q  <= 1'b0;
			ocnt_q <= 2'd0;
		end else begin
			if (opush) owp_q <= !owp_q;
			if (opop) orp_q <= !orp_q;
			if (opush && !opop) ocnt_q <= ocnt_q + 2'd1;
			else if (opop && !opush) ocnt_q <= ocnt_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (opush) oq_q[owp_q] <= res;
	end

	assign empty           = (ocnt_q == 2'd0);
	assign kappa_sq        = oq_q[orp_q].ksq;
	assign zero_separation = oq_q[orp_q].zero;

	a_ocnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		ocnt_q != 2'd3) else $error("result buffer overflow");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		opush |-> ocnt_q != 2'd2) else $error("push into full result buffer");
	a_zero_t: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && dv_vld[41] && dv_s[41].zero) |=> tq_s4 == '0)
		else $error("r term not dropped on zero separation");

endmodule

@@ rtl/core/dipole_pair_kappa_squared.sv @@
// top level: kappa squared orientation factor for a donor/acceptor dipole pair
// pipeline: 51 register stages, counting the one loaded at the accepting edge
//   (front 2, queue 1, product 2, divider 42, finish 3, result buffer 1)
// throughput: one beat per cycle unless stalled (full, or result buffer not popped);
//   the 41 stage quotient pipeline sets the depth
// reset: arst_n clears all valid bits, queue pointers and counts; data is not reset
module dipole_pair_kappa_squared import dpks_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  logic signed [15:0] donor_x,
	input  logic signed [15:0] donor_y,
	input  logic signed [15:0] donor_z,
	input  logic signed [15:0] acceptor_x,
	input  logic signed [15:0] acceptor_y,
	input  logic signed [15:0] acceptor_z,
	input  logic signed [19:0] sep_x,
	input  logic signed [19:0] sep_y,
	input  logic signed [19:0] sep_z,
	output logic               empty,
	input  logic               pop,
	output logic [18:0]        kappa_sq,
	output logic               zero_separation
);

	logic front_adv;
	logic f_vld;
	mid_t f_data;
	logic mid_wr;
	logic mid_rd;
	logic mid_full;
	logic mid_empty;
	mid_t mid_data;

	// front stalls only when the middle queue is full
	assign front_adv = !mid_full;
	assign full      = !front_adv;
	assign mid_wr    = f_vld && front_adv;

	// front: dot products d.a, d.r, a.r, r.r and sign / zero classification
	dpks_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.adv        (front_adv),
		.in_vld     (push),
		.donor_x    (donor_x),
		.donor_y    (donor_y),
		.donor_z    (donor_z),
		.acceptor_x (acceptor_x),
		.acceptor_y (acceptor_y),
		.acceptor_z (acceptor_z),
		.sep_x      (sep_x),
		.sep_y      (sep_y),
		.sep_z      (sep_z),
		.out_vld    (f_vld),
		.out_data   (f_data)
	);

	// decouples front and back so each can stall on its own
	dpks_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (mid_wr),
		.wdata  (f_data),
		.rd     (mid_rd),
		.rdata  (mid_data),
		.full   (mid_full),
		.empty  (mid_empty)
	);

	// back: 3|d.r||a.r| / r.r, k = d.a - t, k squared, result buffer
	dpks_back u_back (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_empty        (mid_empty),
		.in_data         (mid_data),
		.in_rd           (mid_rd),
		.kappa_sq        (kappa_sq),
		.zero_separation (zero_separation),
		.empty           (empty),
		.pop             (pop)
	);

	a_rd_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_rd |-> !mid_empty) else $error("back end read from empty queue");
	a_wr_room: assert property (@(posedge clk) disable iff (!arst_n)
		mid_wr |-> !mid_full) else $error("front end wrote into full queue");
	a_ksq_range: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> kappa_sq <= KSQ_MAX) else $error("kappa squared out of range");

endmodule

@@ tb/sv/dpks_checker.sv @@
// checker: predicts kappa squared for every accepted pair and compares each result beat
module dpks_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  logic               full,
	input  logic signed [15:0] donor_x,
	input  logic signed [15:0] donor_y,
	input  logic signed [15:0] donor_z,
	input  logic signed [15:0] acceptor_x,
	input  logic signed [15:0] acceptor_y,
	input  logic signed [15:0] acceptor_z,
	input  logic signed [19:0] sep_x,
	input  logic signed [19:0] sep_y,
	input  logic signed [19:0] sep_z,
	input  logic               empty,
	input  logic               pop,
	input  logic [18:0]        kappa_sq,
	input  logic               zero_separation,
	output int                 errors,
	output int                 pending
);

	typedef struct packed {
		logic [18:0] ksq;
		logic        zsep;
	} ksq_res_t;

	ksq_res_t want_q[$];

	function automatic ksq_res_t kappa_predict(
		input logic signed [15:0] dx, dy, dz, ax, ay, az,
		input logic signed [19:0] rx, ry, rz);
		ksq_res_t res;
		longint da, dr, ar, rr, t, k;
		logic [127:0] num, q, rem;
		logic [63:0] mdr, mar, km, k2, ksq;
		da = dx * ax + dy * ay + dz * az;
		dr = longint'(dx) * rx + longint'(dy) * ry + longint'(dz) * rz;
		ar = longint'(ax) * rx + longint'(ay) * ry + longint'(az) * rz;
		rr = longint'(rx) * rx + longint'(ry) * ry + longint'(rz) * rz;
		t = 0;
		res.zsep = (rr == 0);
		if (rr != 0) begin
			mdr = dr < 0 ? -dr : dr;
			mar = ar < 0 ? -ar : ar;
			num = 128'(3 * mdr) * 128'(mar);
			q = num / 128'(rr);
			rem = num % 128'(rr);
			if (rem >= 128'(rr) - rem) q = q + 1;
			if (q > (128'd1 << 40)) q = 128'd1 << 40;
			t = ((dr < 0) != (ar < 0)) ? -longint'(q) : longint'(q);
		end
		k = da - t;
		km = k < 0 ? -k : k;
		if (km > (64'd1 << 30)) km = 64'd1 << 30;
		k2 = km * km;
		ksq = (k2 + (64'd1 << 39)) >> 40;
		if (ksq > 64'd262144) ksq = 64'd262144;
		res.ksq = ksq[18:0];
		return res;
	endfunction

	task automatic report(input string what);
		$display("mismatch at %0t: %s", $realtime, what);
		errors++;
	endtask

	assign pending = want_q.size();

	always @(posedge clk) begin
		ksq_res_t w;
		if (arst_n && push && !full)
			want_q.insert(want_q.size(), kappa_predict(donor_x, donor_y, donor_z,
				acceptor_x, acceptor_y, acceptor_z, sep_x, sep_y, sep_z));
		if (arst_n && pop && !empty) begin
			if (want_q.size() == 0) report("result beat with nothing expected");
			else begin
				w = want_q.pop_front();
				if (kappa_sq !== w.ksq)
					report($sformatf("kappa_sq %0d want %0d", kappa_sq, w.ksq));
				if (zero_separation !== w.zsep)
					report($sformatf("zero_separation %0b want %0b", zero_separation,
						w.zsep));
			end
		end
	end

endmodule

@@ tb/sv/tb_dipole_pair_kappa_squared.sv @@
// testbench top: stimulus, idling and verdict for the kappa squared block
module tb_dipole_pair_kappa_squared;
	import dpks_pkg::*;

	localparam int N_RANDOM = 1150;
	localparam int WATCHDOG = 2000;

	logic clk, arst_n, push, pop;
	logic full, empty, zero_separation;
	logic [18:0] kappa_sq;
	logic signed [15:0] donor_x, donor_y, donor_z, acceptor_x, acceptor_y, acceptor_z;
	logic signed [19:0] sep_x, sep_y, sep_z;
	int errors, pending, idle_cycles;

	dipole_pair_kappa_squared u_top (.*);
	dpks_checker u_chk (.*);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// a random Q1.14 component, mostly inside +-1.0 but every bit exercised
	function automatic logic signed [15:0] rand_q14();
		case ($urandom_range(0, 5))
			0: return 16'($urandom);
			1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// separation: short vectors, full range, zero, or full scale extremes
	function automatic logic signed [19:0] rand_sep();
		case ($urandom_range(0, 5))
			0: return 20'($urandom);
			1: return 20'($signed($urandom_range(0, 200)) - 100);
			2: return '0;
			3: return $urandom_range(0, 1) ? 20'sh7FFFF : 20'sh80000;
			default: return 20'($signed($urandom_range(0, 8000)) - 4000);
		endcase
	endfunction

	// one input beat: idle gap, drive, then hold until accepted
	task automatic send_pair(input logic signed [15:0] dx, dy, dz, ax, ay, az,
		input logic signed [19:0] rx, ry, rz);
		int gap;
		gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 5);
		if ($urandom_range(0, 3) == 0) gap = 0;
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		donor_x <= dx; donor_y <= dy; donor_z <= dz;
		acceptor_x <= ax; acceptor_y <= ay; acceptor_z <= az;
		sep_x <= rx; sep_y <= ry; sep_z <= rz;
		@(posedge clk);
		while (full) @(posedge clk);
	endtask

	task automatic send_random();
		send_pair(rand_q14(), rand_q14(), rand_q14(), rand_q14(), rand_q14(),
			rand_q14(), rand_sep(), rand_sep(), rand_sep());
	endtask

	// result side: before each beat drop pop for a random wait, sometimes none, then pop until taken
	initial begin
		int w;
		pop = 1'b0;
		@(posedge arst_n);
		forever begin
			w = $urandom_range(0, 5);
			if ($urandom_range(0, 3) == 0) w = 0;
			if (w > 0) begin
				pop <= 1'b0;
				repeat (w) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
		end
	end

	// watchdog on cycles with no accepted beat
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((push && !full) || (pop && !empty)) idle_cycles = 0;
			else idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("RESULT: ERROR");
				$finish;
			end
		end
	end

	initial begin
		push = 0;
		donor_x = 0; donor_y = 0; donor_z = 0;
		acceptor_x = 0; acceptor_y = 0; acceptor_z = 0;
		sep_x = 0; sep_y = 0; sep_z = 0;
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: zero separation, parallel/perpendicular, extremes, saturation
		send_pair(16384, 0, 0, 16384, 0, 0, 0, 0, 0);
		send_pair(16384, 0, 0, 0, 16384, 0, 0, 0, 0);
		send_pair(16384, 0, 0, 16384, 0, 0, 100, 0, 0);
		send_pair(16384, 0, 0, 16384, 0, 0, 0, 5, 0);
		send_pair(16384, 0, 0, -16384, 0, 0, 7, 0, 0);
		send_pair(0, 16384, 0, 0, 0, 16384, 1, 1, 1);
		send_pair(-16384, -16384, -16384, -16384, -16384, -16384, 1, 1, 1);
		send_pair(16384, 16384, 16384, 16384, 16384, 16384, 0, 0, 0);
		send_pair(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh8000, 16'sh8000,
			20'sh7FFFF, 20'sh7FFFF, 20'sh7FFFF);
		send_pair(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000,
			20'sh80000, 20'sh80000, 20'sh80000);
		send_pair(16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000,
			1, 0, 0);
		send_pair(16'sh7FFF, 16'sh7FFF, 0, 16'sh7FFF, 16'sh7FFF, 0,
			20'sh7FFFF, 20'sh80000, 1);
		send_pair(0, 0, 0, 0, 0, 0, 3, 4, 5);
		send_pair(11585, 11585, 0, 11585, -11585, 0, 20'sh7FFFF, 0, 0);
		send_pair(9459, 9459, 9459, 9459, 9459, -9459, 1, -1, 0);
		send_pair(1, -1, 1, -1, 1, -1, 20'sh80000, 0, 20'sh7FFFF);

		repeat (N_RANDOM) send_random();
		push <= 1'b0;

		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0 && pending == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

@@ sim.f @@
rtl/core/dpks_pkg.sv
rtl/core/dpks_front.sv
rtl/core/dpks_queue.sv
rtl/core/dpks_back.sv
rtl/core/dipole_pair_kappa_squared.sv
tb/sv/dpks_checker.sv
tb/sv/tb_dipole_pair_kappa_squared.sv
